// ===== design/mmpd_pkg.sv =====
// Shared types and constants for the moving-mean peak detector.
// Holds field widths, configuration register indexes and reset values.
// Every other design file imports this package.
`default_nettype none

package mmpd_pkg;

  // Field widths of the stream payloads.
  localparam int INT_W      = 16;
  localparam int THR_W      = 17;
  localparam int PBIN_W     = 12;
  localparam int BEAMNUM_W  = 10;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 40;

  // Configuration port.
  localparam int HMIN_W     = 16;
  localparam int WSIZE_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HMIN        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;

  localparam logic [HMIN_W-1:0]  HMIN_RESET  = 16'd110;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 6'd5;

  // Default sizes handed to the top level.
  localparam int DEF_MAX_WINDOW = 32;
  localparam int DEF_MAX_BINS   = 4096;
  localparam int DEF_MAX_BEAMS  = 1024;

endpackage

`default_nettype wire

// ===== design/mmpd_cell.sv =====
// One cell of the window shift line: holds one past bin intensity.
// On a push it takes its left neighbor's value. Depends on mmpd_pkg.
`default_nettype none

module mmpd_cell
  import mmpd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire logic [INT_W-1:0] d_in,
  output logic      [INT_W-1:0] d_out
);

  logic [INT_W-1:0] data_r;

  // Window contents are only read where the fill count says they are valid.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

`default_nettype wire

// ===== design/moving_mean_peak_detector_core.sv =====
// The closing input beat is captured in ST_IDLE, and out_tvalid rises as that item retires
// from ST_EXEC, whose retire loads the output register holding the result beat.
// Inputs wait until the last item retires; the mean's reciprocal product is registered
// ahead of the update cycle, and the window is one read-modify-write of the cell chain.
// A result waiting on out_tready holds only the next item that also produces a result.
// Reset (rst_n low, synchronous) clears the window and bin counters, peak flag, output valid,
// restores hmin to 110 and window_size to 5; the window cells themselves need no clearing.
`default_nettype none

module moving_mean_peak_detector_core
  import mmpd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int MAX_BEAMS  = DEF_MAX_BEAMS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input bins.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] intensity
  input  wire logic                   in_tuser,   // [0] first_bin
  // Peak results.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [16:0] peak_threshold,
                                                  // [28:17] peak_bin,
                                                  // [38:29] beam_number, [39] zero
  // Configuration writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Window fill count runs from zero up to MAX_WINDOW inclusive.
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = INT_W + CNT_W;
  // The reciprocal scale covers every possible sum, so the truncated
  // estimate is either the exact quotient or one below it.
  localparam int SHIFT  = SUM_W;
  localparam int REC_W  = SHIFT + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int BEAM_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state_r;

  // Configuration registers.
  logic [HMIN_W-1:0]  hmin_r;
  logic [WSIZE_W-1:0] wsize_r;

  // Running state.
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic               inside_r;
  logic [INT_W-1:0]   hi_height_r;
  logic [INT_W-1:0]   lo_height_r;
  logic [BIN_W-1:0]   hi_bin_r;
  logic [BIN_W-1:0]   bin_r;
  logic [BEAM_W-1:0]  beam_r;

  // Captured input beat.
  logic [INT_W-1:0]   int_r;
  logic               first_r;

  // Registered product of the window sum and the reciprocal of the count.
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;

  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Reciprocal table, floor(2^SHIFT / count); entry zero is never used.
  logic [REC_W-1:0]   recip_tab [MAX_WINDOW+1];

  for (genvar g = 0; g <= MAX_WINDOW; g++) begin : g_recip
    localparam logic [63:0] RC = (64'd1 << SHIFT) / ((g == 0) ? 64'd1 : 64'(g));
    assign recip_tab[g] = (g == 0) ? '0 : RC[REC_W-1:0];
  end

  // The product is refreshed every cycle, so it always reflects the state
  // left by the previous item by the time the next one is executed.
  assign prod_nxt = PROD_W'(sum_r) * PROD_W'(recip_tab[count_r]);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Window cell chain: cell 0 holds the newest bin, cell count-1 the oldest.
  logic [INT_W-1:0] cell_q [MAX_WINDOW];
  logic             push;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    mmpd_cell u_cell (
      .clk      (clk),
      .shift_en (push),
      .d_in     ((g == 0) ? int_r : cell_q[(g == 0) ? 0 : g - 1]),
      .d_out    (cell_q[g])
    );
  end

  // Mean: correct the truncated reciprocal estimate by at most one.
  logic [16:0]        q_est;
  logic [SUM_W:0]     q_times_c;
  logic [SUM_W:0]     q_rem;
  logic [INT_W-1:0]   mean;

  always_comb begin
    q_est     = prod_r[SHIFT +: 17];
    q_times_c = (SUM_W + 1)'(q_est) * (SUM_W + 1)'(count_r);
    q_rem     = {1'b0, sum_r} - q_times_c;
    if (first_r || count_r == '0) begin
      mean = '0;
    end else if (q_rem >= (SUM_W + 1)'(count_r)) begin
      mean = INT_W'(q_est + 17'd1);
    end else begin
      mean = INT_W'(q_est);
    end
  end

  // Height of the current bin above the mean, as a signed difference.
  logic [17:0]      height;
  logic             is_peak_bin;
  logic [INT_W-1:0] h;

  assign height      = {2'b00, int_r} - {2'b00, mean};
  assign is_peak_bin = !height[17] && (height[16:0] > {1'b0, hmin_r});
  assign h           = height[INT_W-1:0];

  // A beam start clears the window, the peak and the bin counter first.
  logic [CNT_W-1:0]  count_base;
  logic [SUM_W-1:0]  sum_base;
  logic              inside_cur;
  logic [BIN_W-1:0]  bin_cur;
  logic [BEAM_W-1:0] beam_cur;

  assign count_base = first_r ? '0 : count_r;
  assign sum_base   = first_r ? '0 : sum_r;
  assign inside_cur = first_r ? 1'b0 : inside_r;
  assign bin_cur    = first_r ? '0 : bin_r;

  always_comb begin
    if (!first_r) begin
      beam_cur = beam_r;
    end else if (32'(beam_r) == MAX_BEAMS - 1) begin
      beam_cur = '0;
    end else begin
      beam_cur = beam_r + 1'b1;
    end
  end

  // Peak tracking.
  logic             produce;
  logic             inside_nxt;
  logic [INT_W-1:0] hi_height_nxt;
  logic [INT_W-1:0] lo_height_nxt;
  logic [BIN_W-1:0] hi_bin_nxt;

  always_comb begin
    produce       = 1'b0;
    inside_nxt    = inside_cur;
    hi_height_nxt = hi_height_r;
    lo_height_nxt = lo_height_r;
    hi_bin_nxt    = hi_bin_r;
    priority if (is_peak_bin && !inside_cur) begin
      inside_nxt    = 1'b1;
      hi_height_nxt = h;
      lo_height_nxt = h;
      hi_bin_nxt    = bin_cur;
    end else if (is_peak_bin && h > hi_height_r) begin
      hi_height_nxt = h;
      hi_bin_nxt    = bin_cur;
    end else if (is_peak_bin && h < lo_height_r) begin
      lo_height_nxt = h;
    end else if (!is_peak_bin && inside_cur) begin
      produce    = 1'b1;
      inside_nxt = 1'b0;
    end else begin
      inside_nxt = inside_cur;
    end
  end

  // The item retires unless its result would overwrite one still waiting.
  logic advance;
  logic out_valid_nxt;

  assign advance = (state_r == ST_EXEC) && (!produce || !out_valid_r || out_tready);
  assign push    = advance && !inside_nxt;

  // A new result replaces the one taken in the same cycle; otherwise a waiting one stays.
  assign out_valid_nxt = (advance && produce) || (out_valid_r && !out_tready);

  // Window update: drop the oldest bin once the window is full.
  logic [CNT_W-1:0] win_eff;
  logic             full;
  logic [CNT_W-1:0] oldest_pos;
  logic [INT_W-1:0] evict;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    if (wsize_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(wsize_r) > MAX_WINDOW) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(wsize_r);
    end
  end

  assign full       = count_base >= win_eff;
  assign oldest_pos = count_base - 1'b1;
  assign evict      = cell_q[oldest_pos[IDX_W-1:0]];
  assign sum_nxt    = sum_base - (full ? SUM_W'(evict) : '0) + SUM_W'(int_r);
  assign count_nxt  = full ? count_base : count_base + 1'b1;

  logic [BIN_W-1:0] bin_nxt;

  assign bin_nxt = (32'(bin_cur) == MAX_BINS - 1) ? '0 : bin_cur + 1'b1;

  logic [THR_W-1:0] threshold;

  assign threshold = THR_W'({1'b0, mean} + {1'b0, lo_height_r});

  // Sequencer, window state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hmin_r      <= HMIN_RESET;
      wsize_r     <= WSIZE_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      inside_r    <= 1'b0;
      bin_r       <= '0;
      beam_r      <= BEAM_W'(MAX_BEAMS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HMIN:        hmin_r  <= cfg_data[HMIN_W-1:0];
          CFG_WINDOW_SIZE: wsize_r <= cfg_data[WSIZE_W-1:0];
          default:         hmin_r  <= hmin_r;
        endcase
      end

      out_valid_r <= out_valid_nxt;

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (advance) begin
            state_r  <= ST_IDLE;
            inside_r <= inside_nxt;
            bin_r    <= bin_nxt;
            beam_r   <= beam_cur;
            if (push) begin
              count_r <= count_nxt;
              sum_r   <= sum_nxt;
            end else begin
              count_r <= count_base;
              sum_r   <= sum_base;
            end
            if (produce) begin
              out_data_r <= {1'b0, BEAMNUM_W'(beam_cur), PBIN_W'(hi_bin_r), threshold};
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      int_r   <= in_tdata[INT_W-1:0];
      first_r <= in_tuser;
    end
    if (advance) begin
      hi_height_r <= hi_height_nxt;
      lo_height_r <= lo_height_nxt;
      hi_bin_r    <= hi_bin_nxt;
    end
  end

  // Nothing is taken while reset is held.
  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = rst_n;

endmodule

`default_nettype wire

// ===== design/mmpd_checker.sv =====
// Port-level checks for the moving-mean peak detector.
// Bound to moving_mean_peak_detector_core; depends on mmpd_pkg.
`default_nettype none

module mmpd_checker
  import mmpd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // A waiting result beat holds its payload until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // An accepted bin occupies the block for its update cycle.
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A fresh result only follows an accepted input beat.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result beat without a matching input beat");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The unused top bit of the result payload stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[OUT_TDATA_W-1])
    else $error("result padding bit set");

endmodule

bind moving_mean_peak_detector_core mmpd_checker u_mmpd_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_moving_mean_peak_detector_core.sv =====
// Self-checking testbench for the moving-mean peak detector core.
// Drives sonar bin beats and register writes, predicts or lists every peak report, and
// compares it with the result stream. Depends on mmpd_pkg and the core module.
`default_nettype none

module tb_moving_mean_peak_detector_core;
  import mmpd_pkg::*;

  localparam int WIN_DEPTH = DEF_MAX_WINDOW;

  // One peak report, as the result stream carries it.
  typedef struct packed {
    logic [THR_W-1:0]     threshold;
    logic [PBIN_W-1:0]    bin;
    logic [BEAMNUM_W-1:0] beam;
  } peak_t;

  // How a directed row is checked: by the predictor, by a typed value, or as giving no report.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    logic [INT_W-1:0] level;
    logic             first;
    row_kind_t        kind;
    peak_t            want;
  } stim_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] intensity
  logic                   in_tuser;   // [0] first_bin
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [16:0] peak_threshold, [28:17] peak_bin,
                                      // [38:29] beam_number, [39] zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  moving_mean_peak_detector_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predicted peak reports, oldest first.
  peak_t pending_peaks[$];
  int    err_count;

  // Idle percentages of the sender and the receiver.
  int send_idle;
  int recv_stall;

  // Predictor copy of the block's registers and running state.
  logic [HMIN_W-1:0]  hmin_q;
  logic [WSIZE_W-1:0] wsize_q;
  logic [INT_W-1:0]   win_mem [WIN_DEPTH];
  int unsigned        win_fill;
  int unsigned        win_head;
  logic [20:0]        win_total;
  bit                 peak_open;
  logic [INT_W-1:0]   peak_top;
  logic [INT_W-1:0]   peak_low;
  logic [PBIN_W-1:0]  peak_top_bin;
  logic [PBIN_W-1:0]  bin_idx;
  logic [BEAMNUM_W-1:0] beam_idx;

  // Stimulus generator state: bins left in the beam, its floor, bins left in a bump.
  int beam_left;
  int floor_lvl;
  int bump_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the predicted state by one bin and reports whether a peak closed.
  function automatic bit predict_bin(input logic [INT_W-1:0] level, input logic first,
                                     output peak_t res);
    logic [20:0]       mean;
    logic [PBIN_W-1:0] cur_bin;
    int                height;
    int unsigned       span;
    bit                hit;
    hit = 1'b0;
    res = '0;
    if (first) begin
      beam_idx     = beam_idx + 1'b1;
      win_fill     = 0;
      win_head     = 0;
      win_total    = '0;
      peak_open    = 1'b0;
      peak_top     = '0;
      peak_low     = '0;
      peak_top_bin = '0;
      bin_idx      = '0;
    end
    cur_bin = bin_idx;
    bin_idx = bin_idx + 1'b1;
    mean    = (win_fill > 0) ? 21'(win_total / win_fill) : 21'd0;
    height  = int'(level) - int'(mean);
    if (height > int'(hmin_q)) begin
      if (!peak_open) begin
        peak_top     = INT_W'(height);
        peak_low     = INT_W'(height);
        peak_top_bin = cur_bin;
        peak_open    = 1'b1;
      end else if (height > int'(peak_top)) begin
        peak_top     = INT_W'(height);
        peak_top_bin = cur_bin;
      end else if (height < int'(peak_low)) begin
        peak_low = INT_W'(height);
      end
    end else if (peak_open) begin
      res.threshold = THR_W'(mean + peak_low);
      res.bin       = peak_top_bin;
      res.beam      = beam_idx;
      hit           = 1'b1;
      peak_open     = 1'b0;
      peak_top      = '0;
      peak_top_bin  = '0;
    end
    // The window only moves outside a peak; a size of zero acts as one, and
    // sizes above the store depth saturate.
    if (!peak_open) begin
      span = (wsize_q == 0) ? 1 : (wsize_q > WIN_DEPTH) ? WIN_DEPTH : wsize_q;
      if (win_fill >= span && win_fill > 0) begin
        win_total = win_total - win_mem[win_head];
        win_head  = (win_head + 1) % WIN_DEPTH;
        win_fill  = win_fill - 1;
      end
      win_mem[(win_head + win_fill) % WIN_DEPTH] = level;
      win_total = win_total + level;
      win_fill  = win_fill + 1;
    end
    return hit;
  endfunction

  task automatic set_mode(input idle_mode_t m);
    send_idle  = (m == IDLE_SEND) ? 53 : (m == IDLE_BOTH) ? 13 : 0;
    recv_stall = (m == IDLE_RECV) ? 53 : (m == IDLE_BOTH) ? 13 : 0;
  endtask

  // Sends one bin beat. Entered and left at a falling edge; in_tvalid stays high
  // on return so a following beat can go out back to back.
  task automatic send_bin(input logic [INT_W-1:0] level, input logic first,
                          input row_kind_t kind, input peak_t typed);
    peak_t guess;
    bit    hit;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= level;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    hit = predict_bin(level, first, guess);
    if (kind == ROW_RESULT)
      pending_peaks.insert(pending_peaks.size(), typed);
    else if (kind == ROW_PREDICT && hit)
      pending_peaks.insert(pending_peaks.size(), guess);
    @(negedge clk);
  endtask

  // One register beat; cfg_valid is lowered by the caller.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HMIN)
      hmin_q = data[HMIN_W-1:0];
    else
      wsize_q = data[WSIZE_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] hmin_v,
                            input logic [CFG_DATA_W-1:0] wsize_v);
    write_reg(CFG_HMIN, hmin_v);
    write_reg(CFG_WINDOW_SIZE, wsize_v);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender off until every predicted report has come back.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (pending_peaks.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain, then let the last bin finish, since it may close no peak and still be in flight.
  task automatic settle();
    wait_results();
    repeat (8) @(negedge clk);
  endtask

  // Beams shaped like sonar returns: a quiet floor at or below hmin fills the window,
  // then bumps rise clear of it and fall back, which closes a peak. With breaks set,
  // a few beams are cut short and a few bins are pure noise.
  task automatic run_beams(input int count, input int max_len, input bit breaks);
    int   k;
    int   lvl;
    int   noise;
    logic first;
    for (k = 0; k < count; k++) begin
      first = 1'b0;
      if (beam_left <= 0 || (breaks && $urandom_range(99) < 3)) begin
        first     = 1'b1;
        beam_left = breaks ? int'($urandom_range(max_len, 1)) : max_len;
        floor_lvl = int'($urandom_range(hmin_q, 0));
        bump_left = 0;
      end
      noise = (hmin_q / 4 > 40) ? 40 : int'(hmin_q) / 4;
      if (first) begin
        lvl = floor_lvl;
      end else if (breaks && $urandom_range(99) < 8) begin
        lvl = int'($urandom_range(65535, 0));
      end else if (bump_left > 0) begin
        lvl = floor_lvl + int'(hmin_q) + 1 + int'($urandom_range(3000, 0));
        bump_left--;
      end else begin
        lvl = floor_lvl + int'($urandom_range(2 * noise, 0)) - noise;
        if ($urandom_range(99) < 15)
          bump_left = int'($urandom_range(6, 1));
      end
      if (lvl < 0)
        lvl = 0;
      else if (lvl > 65535)
        lvl = 65535;
      beam_left--;
      send_bin(INT_W'(lvl), first, ROW_PREDICT, '0);
    end
  endtask

  // Receiver: stalls at random, changing at the falling edge.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Result check at the rising edge, field by field against the oldest prediction.
  always @(posedge clk) begin
    peak_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $time, out_tdata);
        err_count++;
      end else begin
        want = pending_peaks.pop_front();
        if (out_tdata[THR_W-1:0] !== want.threshold) begin
          $display("%0t: peak_threshold expected %0d actual %0d", $time, want.threshold,
                   out_tdata[THR_W-1:0]);
          err_count++;
        end
        if (out_tdata[THR_W+PBIN_W-1:THR_W] !== want.bin) begin
          $display("%0t: peak_bin expected %0d actual %0d", $time, want.bin,
                   out_tdata[THR_W+PBIN_W-1:THR_W]);
          err_count++;
        end
        if (out_tdata[THR_W+PBIN_W+BEAMNUM_W-1:THR_W+PBIN_W] !== want.beam) begin
          $display("%0t: beam_number expected %0d actual %0d", $time, want.beam,
                   out_tdata[THR_W+PBIN_W+BEAMNUM_W-1:THR_W+PBIN_W]);
          err_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:THR_W+PBIN_W+BEAMNUM_W] !== '0) begin
          $display("%0t: pad bits expected 0 actual %b", $time,
                   out_tdata[OUT_TDATA_W-1:THR_W+PBIN_W+BEAMNUM_W]);
          err_count++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int        k;
    stim_row_t dir_rows [23];
    // Reset values: hmin 110, window 5. The first rows run before any beam starts,
    // so their report carries the all-ones beam number. A beam start drops an open
    // peak silently. Equal heights leave the peak alone.
    dir_rows = '{
      '{16'd0,     1'b0, ROW_NONE,    '0},
      '{16'd65535, 1'b0, ROW_NONE,    '0},
      '{16'd0,     1'b0, ROW_RESULT,  '{17'd65535, 12'd1, 10'd1023}},
      '{16'd200,   1'b1, ROW_NONE,    '0},
      '{16'd0,     1'b1, ROW_NONE,    '0},
      '{16'd65535, 1'b0, ROW_NONE,    '0},
      '{16'd65535, 1'b0, ROW_NONE,    '0},
      '{16'd111,   1'b0, ROW_NONE,    '0},
      '{16'd110,   1'b0, ROW_RESULT,  '{17'd111, 12'd1, 10'd1}},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd1500,  1'b0, ROW_PREDICT, '0},
      '{16'd3000,  1'b0, ROW_PREDICT, '0},
      '{16'd1200,  1'b0, ROW_PREDICT, '0},
      '{16'd1000,  1'b0, ROW_PREDICT, '0},
      '{16'd0,     1'b1, ROW_PREDICT, '0},
      '{16'd65535, 1'b0, ROW_PREDICT, '0},
      '{16'd65535, 1'b0, ROW_PREDICT, '0},
      '{16'd0,     1'b0, ROW_PREDICT, '0},
      '{16'd32768, 1'b0, ROW_PREDICT, '0}
    };
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count  = 0;
    beam_left  = 0;
    floor_lvl  = 0;
    bump_left  = 0;
    set_mode(IDLE_NONE);
    hmin_q       = HMIN_RESET;
    wsize_q      = WSIZE_RESET;
    win_fill     = 0;
    win_head     = 0;
    win_total    = '0;
    peak_open    = 1'b0;
    peak_top     = '0;
    peak_low     = '0;
    peak_top_bin = '0;
    bin_idx      = '0;
    beam_idx     = '1;
    rst_n        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_bin(dir_rows[i].level, dir_rows[i].first, dir_rows[i].kind, dir_rows[i].want);
    settle();

    // Every bin above the mean is a peak bin; one-bin window.
    set_config(16'd0, 16'd1);
    set_mode(IDLE_NONE);
    run_beams(100, 40, 1'b1);
    settle();

    // No height can exceed the largest hmin, so no report may appear.
    set_config(16'hFFFF, 16'd32);
    set_mode(IDLE_SEND);
    run_beams(60, 40, 1'b1);
    settle();

    set_config(HMIN_RESET, WSIZE_RESET);
    set_mode(IDLE_RECV);
    run_beams(100, 40, 1'b1);
    settle();

    // A window size of zero behaves as one.
    set_config(16'd300, 16'd0);
    set_mode(IDLE_BOTH);
    run_beams(80, 40, 1'b1);
    settle();

    // All-ones data: the size saturates at the store depth, upper bits are ignored.
    set_config(16'($urandom_range(65535, 0)), 16'hFFFF);
    set_mode(IDLE_SEND);
    run_beams(60, 40, 1'b1);
    settle();

    // Shrink the window in the middle of a long beam.
    set_config(16'd200, 16'd32);
    set_mode(IDLE_NONE);
    beam_left = 0;
    run_beams(60, 300, 1'b0);
    settle();
    set_config(16'd200, 16'd2);
    set_mode(IDLE_RECV);
    run_beams(80, 300, 1'b0);
    settle();

    // More than a full cycle of one-bin beams wraps the beam number.
    set_config(HMIN_RESET, WSIZE_RESET);
    set_mode(IDLE_NONE);
    for (k = 0; k < 1030; k++)
      send_bin(16'($urandom), 1'b1, ROW_PREDICT, '0);
    settle();

    // Mixed settings, idle patterns cycling; the sender drains mid-phase once each.
    beam_left = 0;
    for (k = 0; k < 8; k++) begin
      set_config(16'($urandom_range(2000, 20)), 16'($urandom_range(32, 1)));
      set_mode(idle_mode_t'(k % 4));
      run_beams(10, 40, 1'b1);
      wait_results();
      run_beams(10, 40, 1'b1);
      settle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
